[sv/rwt_pkg.sv]
// Shared types and codes of the retransmit window tracker.
// Used by the register block, the controller, the datapath and the top level.
`timescale 1ns / 1ps
package rwt_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int TIME_BITS_DEF    = 32;

    localparam logic [3:0]  SEQ_MASK  = 4'h0F;
    localparam logic [3:0]  HALF_SEQ  = 4'h08;
    localparam logic [63:0] RTT_SAT   = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_SEND  = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd_e;

    typedef enum logic [2:0] {
        KIND_SENT      = 3'd0,
        KIND_REFUSED   = 3'd1,
        KIND_ACK_DONE  = 3'd2,
        KIND_RETX      = 3'd3,
        KIND_DROPPED   = 3'd4,
        KIND_TICK_DONE = 3'd5,
        KIND_CLEARED   = 3'd6
    } t_kind_e;

    typedef enum logic [1:0] {
        REG_WINDOW_LIMIT = 2'd0,
        REG_RETRY_LIMIT  = 2'd1,
        REG_RTT_ENABLE   = 2'd2
    } t_reg_e;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_CAPTURE   = 4'd1,
        OP_SEND      = 4'd2,
        OP_SEARCH    = 4'd3,
        OP_POP       = 4'd4,
        OP_ACK_DONE  = 4'd5,
        OP_CHECK     = 4'd6,
        OP_SHIFT     = 4'd7,
        OP_CLEAR     = 4'd8
    } t_op_e;

    typedef struct packed {
        logic [3:0] window_limit;
        logic [3:0] retry_limit;
        logic       rtt_enable;
    } t_cfg;

    typedef struct packed {
        t_cmd_e cmd;
        logic   search_skip;
        logic   search_done;
        logic   pop_more;
        logic   check_end;
        logic   check_drop;
        logic   shift_end;
    } t_dp_sts;

endpackage

[sv/rwt_regs.sv]
// Configuration registers of the retransmit window tracker behind an APB port.
// Depends on rwt_pkg for the register codes and the configuration struct.
`timescale 1ns / 1ps
module rwt_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output rwt_pkg::t_cfg o_cfg
);
    import rwt_pkg::*;

    t_cfg   r_cfg;
    t_cfg   n_cfg;
    t_reg_e reg_sel;
    logic   wr_en;

    assign reg_sel = t_reg_e'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_sel)
                REG_WINDOW_LIMIT: n_cfg.window_limit = pwdata[3:0];
                REG_RETRY_LIMIT:  n_cfg.retry_limit  = pwdata[3:0];
                REG_RTT_ENABLE:   n_cfg.rtt_enable   = pwdata[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_WINDOW_LIMIT: prdata = {28'd0, r_cfg.window_limit};
            REG_RETRY_LIMIT:  prdata = {28'd0, r_cfg.retry_limit};
            REG_RTT_ENABLE:   prdata = {31'd0, r_cfg.rtt_enable};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_limit <= 4'd8;
            r_cfg.retry_limit  <= 4'd5;
            r_cfg.rtt_enable   <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[sv/rwt_ctrl.sv]
// Sequencing state machine of the retransmit window tracker.
// Depends on rwt_pkg for the operation codes and the datapath status struct.
`timescale 1ns / 1ps
module rwt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rwt_pkg::t_dp_sts i_sts,
    output rwt_pkg::t_op_e   o_op,
    output logic             o_busy
);
    import rwt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_SEND   = 9'b000000100,
        S_SEARCH = 9'b000001000,
        S_POP    = 9'b000010000,
        S_ACKD   = 9'b000100000,
        S_CHECK  = 9'b001000000,
        S_SHIFT  = 9'b010000000,
        S_CLEAR  = 9'b100000000
    } t_state_e;

    t_state_e r_state;
    t_state_e n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = OP_CAPTURE;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.cmd)
                    CMD_SEND:  n_state = S_SEND;
                    CMD_ACK:   n_state = i_sts.search_skip ? S_POP : S_SEARCH;
                    CMD_TICK:  n_state = S_CHECK;
                    CMD_CLEAR: n_state = S_CLEAR;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_SEND: begin
                o_op    = OP_SEND;
                n_state = S_IDLE;
            end
            S_SEARCH: begin
                o_op = OP_SEARCH;
                if (i_sts.search_done) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                o_op = OP_POP;
                if (!i_sts.pop_more) begin
                    n_state = S_ACKD;
                end
            end
            S_ACKD: begin
                o_op    = OP_ACK_DONE;
                n_state = S_IDLE;
            end
            S_CHECK: begin
                o_op = OP_CHECK;
                if (i_sts.check_end) begin
                    n_state = S_IDLE;
                end else if (i_sts.check_drop) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_op = OP_SHIFT;
                if (i_sts.shift_end) begin
                    n_state = S_CHECK;
                end
            end
            S_CLEAR: begin
                o_op    = OP_CLEAR;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/rwt_dpath.sv]
// Window storage, ring pointers and result registers of the tracker.
// Depends on rwt_pkg; driven one operation per cycle by rwt_ctrl.
`timescale 1ns / 1ps
module rwt_dpath #(
    parameter int WINDOW_DEPTH = rwt_pkg::WINDOW_DEPTH_DEF,
    parameter int TIME_BITS    = rwt_pkg::TIME_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rwt_pkg::t_op_e   i_op,
    input  rwt_pkg::t_cfg    i_cfg,
    input  logic [1:0]       i_command,
    input  logic [3:0]       i_ack_seq,
    input  logic [7:0]       i_payload_tag,
    input  logic [31:0]      i_now_ticks,
    input  logic [31:0]      i_timeout_ticks,
    output rwt_pkg::t_dp_sts o_sts,
    output logic             o_valid,
    output logic [2:0]       o_kind,
    output logic [3:0]       o_seq,
    output logic [7:0]       o_tag_out,
    output logic             o_rtt_valid,
    output logic [31:0]      o_rtt_ticks,
    output logic [3:0]       o_pending_count,
    output logic             o_last
);
    import rwt_pkg::*;

    localparam int SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int PW = CW + 1;

    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                               input logic [CW-1:0] pos);
        logic [PW-1:0] s;
        s = PW'(base) + PW'(pos);
        if (s >= PW'(WINDOW_DEPTH)) begin
            s = s - PW'(WINDOW_DEPTH);
        end
        return s[SW-1:0];
    endfunction

    // Entry storage, no reset: only entries below the count are read.
    logic [3:0]           r_eseq   [WINDOW_DEPTH];
    logic [TIME_BITS-1:0] r_etime  [WINDOW_DEPTH];
    logic [3:0]           r_eretry [WINDOW_DEPTH];
    logic [7:0]           r_etag   [WINDOW_DEPTH];

    // Control state.
    logic [CW-1:0] r_cnt,      n_cnt;
    logic [SW-1:0] r_oldest,   n_oldest;
    logic [3:0]    r_next_seq, n_next_seq;
    logic          r_valid,    n_valid;

    // Request and scratch registers.
    t_cmd_e               r_cmd;
    logic [3:0]           r_ack;
    logic [7:0]           r_tag;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_rto;
    logic [CW-1:0]        r_pos,  n_pos;
    logic [CW-1:0]        r_q,    n_q;
    logic                 r_rv,   n_rv;
    logic [31:0]          r_rtt,  n_rtt;
    logic [3:0]           r_ds,   n_ds;
    logic [7:0]           r_dt,   n_dt;

    // Result registers.
    logic [2:0]  r_kind,  n_kind;
    logic [3:0]  r_seq,   n_seq;
    logic [7:0]  r_otag,  n_otag;
    logic        r_orv,   n_orv;
    logic [31:0] r_ortt,  n_ortt;
    logic [3:0]  r_opend, n_opend;
    logic        r_last,  n_last;

    // Read and write port.
    logic [CW-1:0]        rd_pos;
    logic [SW-1:0]        rd_slot;
    logic [CW-1:0]        wr_pos;
    logic [SW-1:0]        wr_slot;
    logic                 wr_en;
    logic [3:0]           wr_seq;
    logic [TIME_BITS-1:0] wr_time;
    logic [3:0]           wr_retry;
    logic [7:0]           wr_tag;

    logic [3:0]           e_seq;
    logic [TIME_BITS-1:0] e_time;
    logic [3:0]           e_retry;
    logic [7:0]           e_tag;
    logic [TIME_BITS-1:0] age;
    logic [3:0]           lim;
    logic                 full;
    logic [3:0]           seq_gap;
    logic                 pos_last;
    logic                 q_last;

    always_comb begin
        case (i_op)
            OP_SHIFT: rd_pos = r_q + CW'(1);
            OP_POP:   rd_pos = '0;
            default:  rd_pos = r_pos;
        endcase
    end

    assign rd_slot = slot_of(r_oldest, rd_pos);
    assign wr_pos  = (i_op == OP_SEND) ? r_cnt : ((i_op == OP_SHIFT) ? r_q : r_pos);
    assign wr_slot = slot_of(r_oldest, wr_pos);

    assign e_seq   = r_eseq[rd_slot];
    assign e_time  = r_etime[rd_slot];
    assign e_retry = r_eretry[rd_slot];
    assign e_tag   = r_etag[rd_slot];

    assign age      = r_now - e_time;
    assign lim      = (i_cfg.window_limit < 4'(WINDOW_DEPTH)) ? i_cfg.window_limit
                                                             : 4'(WINDOW_DEPTH);
    assign full     = (4'(r_cnt) >= lim);
    assign seq_gap  = (r_ack - e_seq) & SEQ_MASK;
    assign pos_last = ((PW'(r_pos) + PW'(1)) >= PW'(r_cnt));
    assign q_last   = ((PW'(r_q) + PW'(1)) >= PW'(r_cnt));

    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.search_skip = !i_cfg.rtt_enable || (r_cnt == '0);
        o_sts.search_done = (e_seq == r_ack) || pos_last;
        o_sts.pop_more    = (r_cnt != '0) && ((seq_gap & HALF_SEQ) == 4'd0) &&
                            (e_seq != r_ack);
        o_sts.check_end   = (r_pos >= r_cnt);
        o_sts.check_drop  = (age >= r_rto) && (e_retry >= i_cfg.retry_limit);
        o_sts.shift_end   = q_last;
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_oldest   = r_oldest;
        n_next_seq = r_next_seq;
        n_pos      = r_pos;
        n_q        = r_q;
        n_rv       = r_rv;
        n_rtt      = r_rtt;
        n_ds       = r_ds;
        n_dt       = r_dt;
        n_valid    = 1'b0;
        n_kind     = r_kind;
        n_seq      = r_seq;
        n_otag     = 8'd0;
        n_orv      = 1'b0;
        n_ortt     = 32'd0;
        n_opend    = r_opend;
        n_last     = 1'b1;
        wr_en      = 1'b0;
        wr_seq     = e_seq;
        wr_time    = r_now;
        wr_retry   = 4'(e_retry + 4'd1);
        wr_tag     = e_tag;
        case (i_op)
            OP_CAPTURE: begin
                n_pos = '0;
                n_rv  = 1'b0;
                n_rtt = 32'd0;
            end
            OP_SEND: begin
                n_valid = 1'b1;
                n_seq   = r_next_seq;
                if (full) begin
                    n_kind  = KIND_REFUSED;
                    n_opend = 4'(r_cnt);
                end else begin
                    wr_en      = 1'b1;
                    wr_seq     = r_next_seq;
                    wr_retry   = 4'd0;
                    wr_tag     = r_tag;
                    n_cnt      = r_cnt + CW'(1);
                    n_kind     = KIND_SENT;
                    n_otag     = r_tag;
                    n_opend    = 4'(r_cnt + CW'(1));
                    n_next_seq = (r_next_seq + 4'd1) & SEQ_MASK;
                end
            end
            OP_SEARCH: begin
                n_pos = r_pos + CW'(1);
                if (e_seq == r_ack) begin
                    n_rv  = 1'b1;
                    n_rtt = (age > TIME_BITS'(RTT_SAT)) ? 32'hFFFF_FFFF : 32'(age);
                end
            end
            OP_POP: begin
                if ((r_cnt != '0) && ((seq_gap & HALF_SEQ) == 4'd0)) begin
                    n_oldest = slot_of(r_oldest, CW'(1));
                    n_cnt    = r_cnt - CW'(1);
                end
            end
            OP_ACK_DONE: begin
                n_valid = 1'b1;
                n_kind  = KIND_ACK_DONE;
                n_seq   = r_ack;
                n_orv   = r_rv;
                n_ortt  = r_rtt;
                n_opend = 4'(r_cnt);
            end
            OP_CHECK: begin
                if (r_pos >= r_cnt) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_TICK_DONE;
                    n_seq   = 4'd0;
                    n_opend = 4'(r_cnt);
                end else if (age >= r_rto) begin
                    if (e_retry >= i_cfg.retry_limit) begin
                        n_ds = e_seq;
                        n_dt = e_tag;
                        n_q  = r_pos;
                    end else begin
                        wr_en   = 1'b1;
                        n_valid = 1'b1;
                        n_kind  = KIND_RETX;
                        n_seq   = e_seq;
                        n_otag  = e_tag;
                        n_opend = 4'(r_cnt);
                        n_last  = 1'b0;
                        n_pos   = r_pos + CW'(1);
                    end
                end else begin
                    n_pos = r_pos + CW'(1);
                end
            end
            OP_SHIFT: begin
                if (q_last) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_valid = 1'b1;
                    n_kind  = KIND_DROPPED;
                    n_seq   = r_ds;
                    n_otag  = r_dt;
                    n_opend = 4'(r_cnt - CW'(1));
                    n_last  = 1'b0;
                end else begin
                    wr_en    = 1'b1;
                    wr_time  = e_time;
                    wr_retry = e_retry;
                    n_q      = r_q + CW'(1);
                end
            end
            OP_CLEAR: begin
                n_cnt      = '0;
                n_oldest   = '0;
                n_next_seq = 4'd0;
                n_valid    = 1'b1;
                n_kind     = KIND_CLEARED;
                n_seq      = 4'd0;
                n_opend    = 4'd0;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_oldest   <= '0;
            r_next_seq <= 4'd0;
            r_valid    <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_oldest   <= n_oldest;
            r_next_seq <= n_next_seq;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_CAPTURE) begin
            r_cmd <= t_cmd_e'(i_command);
            r_ack <= i_ack_seq;
            r_tag <= i_payload_tag;
            r_now <= TIME_BITS'(i_now_ticks);
            r_rto <= TIME_BITS'(i_timeout_ticks);
        end
        r_pos   <= n_pos;
        r_q     <= n_q;
        r_rv    <= n_rv;
        r_rtt   <= n_rtt;
        r_ds    <= n_ds;
        r_dt    <= n_dt;
        r_kind  <= n_kind;
        r_seq   <= n_seq;
        r_otag  <= n_otag;
        r_orv   <= n_orv;
        r_ortt  <= n_ortt;
        r_opend <= n_opend;
        r_last  <= n_last;
        if (wr_en) begin
            r_eseq[wr_slot]   <= wr_seq;
            r_etime[wr_slot]  <= wr_time;
            r_eretry[wr_slot] <= wr_retry;
            r_etag[wr_slot]   <= wr_tag;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_seq           = r_seq;
    assign o_tag_out       = r_otag;
    assign o_rtt_valid     = r_orv;
    assign o_rtt_ticks     = r_ortt;
    assign o_pending_count = r_opend;
    assign o_last          = r_last;

endmodule

[sv/retransmit_window_tracker.sv]
// Top level of the retransmit window tracker: registers, controller, datapath.
// Depends on rwt_pkg, rwt_regs, rwt_ctrl and rwt_dpath.
`timescale 1ns / 1ps
//
//  Channel   Handshake                         Payload
//  -------   -------------------------------   ------------------------------------
//  request   start high while busy low         i_command, i_ack_seq, i_payload_tag,
//                                              i_now_ticks, i_timeout_ticks
//  result    o_valid high for one cycle        o_kind, o_seq, o_tag_out, o_rtt_valid,
//                                              o_rtt_ticks, o_pending_count, o_last
//  config    APB write, psel penable pwrite    paddr, pwdata, prdata
//
// A send or a clear passes through the decode state and its own state to its
// result. An ack, with round-trip times enabled, first searches the window entry
// by entry for its round-trip time, then removes entries from the oldest end one
// at a time and ends in the ack-done state. A tick inspects the entries one at a
// time, and each drop moves the later entries up a slot one at a time; all of this
// comes from the single entry read port stepping through the window ring. The reset
// is synchronous and active low; it empties the window and loads the register
// defaults, and no clearing pass follows. Results are shown for exactly one cycle
// and cannot be stalled; busy stays high until the final result of a request is out.
module retransmit_window_tracker #(
    parameter int WINDOW_DEPTH = rwt_pkg::WINDOW_DEPTH_DEF,
    parameter int TIME_BITS    = rwt_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [3:0]  i_ack_seq,
    input  logic [7:0]  i_payload_tag,
    input  logic [31:0] i_now_ticks,
    input  logic [31:0] i_timeout_ticks,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_seq,
    output logic [7:0]  o_tag_out,
    output logic        o_rtt_valid,
    output logic [31:0] o_rtt_ticks,
    output logic [3:0]  o_pending_count,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rwt_pkg::*;

    t_cfg    cfg;
    t_op_e   op;
    t_dp_sts sts;

    // The register block is to be changed only while the tracker is idle; it does not enforce this.
    rwt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The controller issues one datapath operation per cycle.
    rwt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_op    (op),
        .o_busy  (busy)
    );

    // The datapath holds the window ring and registers every result.
    rwt_dpath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TIME_BITS    (TIME_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .i_cfg           (cfg),
        .i_command       (i_command),
        .i_ack_seq       (i_ack_seq),
        .i_payload_tag   (i_payload_tag),
        .i_now_ticks     (i_now_ticks),
        .i_timeout_ticks (i_timeout_ticks),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_seq           (o_seq),
        .o_tag_out       (o_tag_out),
        .o_rtt_valid     (o_rtt_valid),
        .o_rtt_ticks     (o_rtt_ticks),
        .o_pending_count (o_pending_count),
        .o_last          (o_last)
    );

    // The final result of a request appears only once the controller is idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("final result shown while busy");

    // A result that is not the final one belongs to a tick still in progress.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("intermediate result while idle");

    // An accepted request keeps the tracker busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    // The pending count never exceeds the window depth.
    a_pend_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pending_count <= 4'(WINDOW_DEPTH)))
        else $error("pending count above window depth");

endmodule

[sim/tb.sv]
// Self-checking testbench for retransmit_window_tracker: directed table, then random
// link traffic in three idling phases, checked against a behavioral window model.
// Depends on rwt_pkg and the retransmit_window_tracker RTL.
`timescale 1ns / 1ps
module tb;
    import rwt_pkg::*;

    localparam int RUN_LIMIT  = 400000;
    localparam int DRAIN_WAIT = 40;
    localparam int RAND_ITEMS = 120;

    typedef struct {
        t_kind_e     kind;
        logic [3:0]  seq;
        logic [7:0]  tag;
        logic        rtt_valid;
        logic [31:0] rtt;
        logic [3:0]  pending;
        logic        last;
    } t_window_result;

    typedef struct {
        t_cmd_e      cmd;
        logic [3:0]  ack;
        logic [7:0]  tag;
        logic [31:0] now;
        logic [31:0] rto;
        bit          typed;
        t_kind_e     kind;
        logic [3:0]  seq;
        logic [3:0]  pending;
    } t_link_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = '0;
    logic [3:0]  i_ack_seq = '0;
    logic [7:0]  i_payload_tag = '0;
    logic [31:0] i_now_ticks = '0;
    logic [31:0] i_timeout_ticks = '0;
    logic        o_valid;
    logic [2:0]  o_kind;
    logic [3:0]  o_seq;
    logic [7:0]  o_tag_out;
    logic        o_rtt_valid;
    logic [31:0] o_rtt_ticks;
    logic [3:0]  o_pending_count;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    retransmit_window_tracker i_dut (.*);

    always #10 i_clk = ~i_clk;

    // Model state of the window ring and its registers.
    logic [3:0]  win_seq [8];
    logic [31:0] win_time [8];
    logic [3:0]  win_retries [8];
    logic [7:0]  win_tag [8];
    bit          win_valid [8];
    logic [2:0]  oldest;
    logic [3:0]  send_seq;
    logic [3:0]  window_limit_q;
    logic [3:0]  retry_limit_q;
    logic        rtt_enable_q;

    t_window_result pending_results[$];
    t_link_row      link_table[$];
    int             errors = 0;
    int             cycles = 0;
    int             sender_idle_pct = 0;
    logic [31:0]    clock_now = 32'd0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic logic [2:0] ring(input int pos);
        return 3'((int'(oldest) + pos) % 8);
    endfunction

    function automatic int entries_held();
        int n;
        n = 0;
        for (int i = 0; i < 8; i++) n += win_valid[i];
        return n;
    endfunction

    task automatic push_result(input t_kind_e kind, input logic [3:0] seq,
                               input logic [7:0] tag, input logic rv,
                               input logic [31:0] rtt, input int cnt);
        t_window_result r;
        r = '{kind, seq, tag, rv, rtt, 4'(cnt), 1'b0};
        pending_results = {pending_results, r};
    endtask

    task automatic clear_window();
        for (int i = 0; i < 8; i++) win_valid[i] = 0;
        oldest = '0;
        send_seq = '0;
    endtask

    // Works out the results of one accepted request and updates the window.
    task automatic predict_window(input t_link_row r);
        int          cnt, lim, p;
        logic [2:0]  s, a, b;
        logic [3:0]  ds, fs;
        logic [7:0]  dt;
        logic [31:0] rtt;
        logic        rv;
        bit          stop;
        cnt = entries_held();
        case (r.cmd)
            CMD_SEND: begin
                lim = (window_limit_q < 8) ? int'(window_limit_q) : 8;
                if (cnt >= lim) begin
                    push_result(KIND_REFUSED, send_seq, 8'd0, 1'b0, 32'd0, cnt);
                end else begin
                    s = ring(cnt);
                    win_seq[s] = send_seq;
                    win_time[s] = r.now;
                    win_retries[s] = '0;
                    win_tag[s] = r.tag;
                    win_valid[s] = 1;
                    cnt++;
                    push_result(KIND_SENT, send_seq, r.tag, 1'b0, 32'd0, cnt);
                    send_seq = send_seq + 4'd1;
                end
            end
            CMD_ACK: begin
                rv = 1'b0;
                rtt = '0;
                if (rtt_enable_q) begin
                    for (p = 0; p < cnt; p++) begin
                        s = ring(p);
                        if (!rv && win_seq[s] == r.ack) begin
                            rtt = r.now - win_time[s];
                            rv = 1'b1;
                        end
                    end
                end
                // Pop from the oldest end while the entry is not ahead of the ack.
                stop = 0;
                while (cnt > 0 && !stop) begin
                    fs = win_seq[oldest];
                    if (4'(r.ack - fs) >= HALF_SEQ) begin
                        stop = 1;
                    end else begin
                        win_valid[oldest] = 0;
                        oldest = oldest + 3'd1;
                        cnt--;
                        if (fs == r.ack) stop = 1;
                    end
                end
                push_result(KIND_ACK_DONE, r.ack, 8'd0, rv, rtt, cnt);
            end
            CMD_TICK: begin
                p = 0;
                while (p < cnt) begin
                    s = ring(p);
                    if (32'(r.now - win_time[s]) >= r.rto) begin
                        if (win_retries[s] >= retry_limit_q) begin
                            ds = win_seq[s];
                            dt = win_tag[s];
                            for (int q = p; q + 1 < cnt; q++) begin
                                a = ring(q);
                                b = ring(q + 1);
                                win_seq[a] = win_seq[b];
                                win_time[a] = win_time[b];
                                win_retries[a] = win_retries[b];
                                win_tag[a] = win_tag[b];
                            end
                            cnt--;
                            win_valid[ring(cnt)] = 0;
                            push_result(KIND_DROPPED, ds, dt, 1'b0, 32'd0, cnt);
                            continue;
                        end
                        win_time[s] = r.now;
                        win_retries[s] = win_retries[s] + 4'd1;
                        push_result(KIND_RETX, win_seq[s], win_tag[s], 1'b0, 32'd0, cnt);
                    end
                    p++;
                end
                push_result(KIND_TICK_DONE, 4'd0, 8'd0, 1'b0, 32'd0, cnt);
            end
            default: begin
                clear_window();
                push_result(KIND_CLEARED, 4'd0, 8'd0, 1'b0, 32'd0, 0);
            end
        endcase
        pending_results[$].last = 1'b1;
    endtask

    // Every result the block shows is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_window_result e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d seq %0d", o_kind, o_seq);
                errors++;
            end else begin
                e = pending_results[0];
                pending_results.delete(0);
                if (o_kind != e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, o_kind);
                    errors++;
                end
                if (o_seq != e.seq) begin
                    $error("seq: expected %0d, got %0d", e.seq, o_seq);
                    errors++;
                end
                if (o_tag_out != e.tag) begin
                    $error("tag_out: expected %0d, got %0d", e.tag, o_tag_out);
                    errors++;
                end
                if (o_rtt_valid != e.rtt_valid) begin
                    $error("rtt_valid: expected %0d, got %0d", e.rtt_valid, o_rtt_valid);
                    errors++;
                end
                if (o_rtt_ticks != e.rtt) begin
                    $error("rtt_ticks: expected %0d, got %0d", e.rtt, o_rtt_ticks);
                    errors++;
                end
                if (o_pending_count != e.pending) begin
                    $error("pending_count: expected %0d, got %0d", e.pending,
                           o_pending_count);
                    errors++;
                end
                if (o_last != e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_last);
                    errors++;
                end
            end
        end
    end

    // Holds start high until the block takes the request, then idles at random.
    task automatic issue_request(input t_link_row r);
        int base;
        i_command <= r.cmd;
        i_ack_seq <= r.ack;
        i_payload_tag <= r.tag;
        i_now_ticks <= r.now;
        i_timeout_ticks <= r.rto;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        base = pending_results.size();
        predict_window(r);
        if (r.typed) begin
            pending_results[base].kind = r.kind;
            pending_results[base].seq = r.seq;
            pending_results[base].pending = r.pending;
        end
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // APB write with a setup and an access phase; the register takes the value at the access edge.
    task automatic write_reg(input t_reg_e idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(idx) << 2;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WINDOW_LIMIT: window_limit_q = value[3:0];
            REG_RETRY_LIMIT:  retry_limit_q = value[3:0];
            default:          rtt_enable_q = value[0];
        endcase
    endtask

    task automatic add_row(input t_cmd_e cmd, input logic [3:0] ack,
                           input logic [7:0] tag, input logic [31:0] now,
                           input logic [31:0] rto);
        t_link_row r;
        r = '{cmd, ack, tag, now, rto, 0, KIND_SENT, 4'd0, 4'd0};
        link_table = {link_table, r};
    endtask

    task automatic add_typed(input t_cmd_e cmd, input logic [3:0] ack,
                             input logic [7:0] tag, input logic [31:0] now,
                             input t_kind_e kind, input logic [3:0] seq,
                             input logic [3:0] cnt);
        t_link_row r;
        r = '{cmd, ack, tag, now, 32'd0, 1, kind, seq, cnt};
        link_table = {link_table, r};
    endtask

    // Random traffic: mostly sends and acks near the outstanding sequence numbers,
    // with ticks against a slowly advancing clock and an occasional clear.
    task automatic random_traffic(input int count);
        t_link_row r;
        int        pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            clock_now = clock_now + $urandom_range(0, 12);
            if ($urandom_range(19) == 0) clock_now = $urandom;
            r = '{CMD_SEND, 4'($urandom), 8'($urandom), clock_now, 32'd0,
                  0, KIND_SENT, 4'd0, 4'd0};
            if ($urandom_range(9) == 0) r.now = $urandom;
            if (pick < 40) begin
                r.cmd = CMD_SEND;
            end else if (pick < 70) begin
                r.cmd = CMD_ACK;
                if (pick < 64) r.ack = send_seq - 4'($urandom_range(1, 8));
            end else if (pick < 96) begin
                r.cmd = CMD_TICK;
                r.rto = ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 40);
            end else begin
                r.cmd = CMD_CLEAR;
            end
            issue_request(r);
        end
    endtask

    initial begin
        window_limit_q = 4'd8;
        retry_limit_q = 4'd5;
        rtt_enable_q = 1'b1;
        clear_window();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty window, fill to the full window, acks, timeouts, drops.
        add_typed(CMD_CLEAR, 4'd0, 8'd0, 32'd0, KIND_CLEARED, 4'd0, 4'd0);
        add_typed(CMD_TICK, 4'd0, 8'd0, 32'd0, KIND_TICK_DONE, 4'd0, 4'd0);
        add_typed(CMD_ACK, 4'd15, 8'd0, 32'hFFFF_FFFF, KIND_ACK_DONE, 4'd15, 4'd0);
        for (int i = 0; i < 8; i++)
            add_typed(CMD_SEND, 4'd0, (i % 2) ? 8'hFF : 8'(i * 17), 32'(i),
                      KIND_SENT, 4'(i), 4'(i + 1));
        add_typed(CMD_SEND, 4'd0, 8'hA5, 32'd9, KIND_REFUSED, 4'd8, 4'd8);
        add_row(CMD_ACK, 4'd1, 8'd0, 32'hFFFF_FFFF, 32'd0);
        add_row(CMD_ACK, 4'd12, 8'd0, 32'd20, 32'd0);
        add_row(CMD_TICK, 4'd0, 8'd0, 32'd100, 32'hFFFF_FFFF);
        for (int i = 0; i < 7; i++)
            add_row(CMD_TICK, 4'd0, 8'd0, 32'(1000 + i), 32'd0);
        add_row(CMD_SEND, 4'd0, 8'h3C, 32'hFFFF_FFF0, 32'd0);
        add_row(CMD_ACK, 4'd15, 8'd0, 32'h0000_0010, 32'd0);
        foreach (link_table[i]) issue_request(link_table[i]);
        wait_idle();

        // Small window, no retries, no round-trip reports; sender idles occasionally.
        write_reg(REG_WINDOW_LIMIT, 32'd1);
        write_reg(REG_RETRY_LIMIT, 32'd0);
        write_reg(REG_RTT_ENABLE, 32'd0);
        sender_idle_pct = 14;
        random_traffic(RAND_ITEMS);
        wait_idle();

        // A window limit of zero refuses every send; then a mid-range setting.
        write_reg(REG_WINDOW_LIMIT, 32'd0);
        write_reg(REG_RETRY_LIMIT, 32'd15);
        write_reg(REG_RTT_ENABLE, 32'd1);
        sender_idle_pct = 81;
        random_traffic(20);
        wait_idle();
        write_reg(REG_WINDOW_LIMIT, 32'($urandom_range(2, 7)));
        write_reg(REG_RETRY_LIMIT, 32'($urandom_range(1, 4)));
        random_traffic(RAND_ITEMS - 20);
        wait_idle();

        // Full window with the highest limit value, back to back.
        write_reg(REG_WINDOW_LIMIT, 32'd15);
        write_reg(REG_RETRY_LIMIT, 32'd2);
        sender_idle_pct = 0;
        random_traffic(RAND_ITEMS);
        wait_idle();

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
